### sv/gte_pkg.sv
// shared types and constants for the graph traversal engine
`timescale 1ns / 1ps

package gte_pkg;

    // fixed field widths
    localparam int NODE_W      = 4;
    localparam int CFG_W       = 5;
    localparam int TALLY_W     = 5;
    localparam int MAX_RESULTS = 16;

    // node count after reset
    localparam logic [CFG_W-1:0] NODE_COUNT_RESET = 5'd16;

    // request modes
    typedef enum logic [1:0] {
        MODE_CLEAR = 2'd0,
        MODE_ADD   = 2'd1,
        MODE_BFS   = 2'd2,
        MODE_DFS   = 2'd3
    } t_mode;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD_A,
        S_ADD_B,
        S_BSCAN,
        S_BNODE,
        S_DSCAN,
        S_DPOP,
        S_FIN
    } t_state;

    // input request
    typedef struct packed {
        t_mode             mode;
        logic [NODE_W-1:0] node_a;
        logic [NODE_W-1:0] node_b;
    } t_req;

    // result item
    typedef struct packed {
        logic [NODE_W-1:0] visited_node;
        logic              last;
    } t_res;

    // walk events toward the result stage
    typedef struct packed {
        logic              reach;
        logic              first;
        logic [NODE_W-1:0] node;
        logic              finish;
    } t_emit;

endpackage

### sv/gte_result_out.sv
// result stage: holds the latest reached node and strobes results with the last flag
`timescale 1ns / 1ps

module gte_result_out (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  gte_pkg::t_emit i_emit,
    output logic           o_res_valid,
    output gte_pkg::t_res  o_res
);
    import gte_pkg::*;

    logic [NODE_W-1:0] r_pend;
    t_res              r_res;
    logic              r_res_vld;
    logic              push_prev;

    // a new node releases the one held before it
    assign push_prev = i_emit.reach && !i_emit.first;

    // strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_vld <= 1'b0;
        end else begin
            r_res_vld <= push_prev || i_emit.finish;
        end
    end

    // payload and held node
    always_ff @(posedge i_clk) begin
        if (push_prev) begin
            r_res <= '{visited_node: r_pend, last: 1'b0};
        end else if (i_emit.finish) begin
            r_res <= '{visited_node: r_pend, last: 1'b1};
        end
        if (i_emit.reach) begin
            r_pend <= i_emit.node;
        end
    end

    assign o_res_valid = r_res_vld;
    assign o_res       = r_res;

`ifndef NO_ASSERTIONS
    // a node is never found in the finishing cycle
    a_reach_finish_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_emit.reach && i_emit.finish))
        else $error("reach and finish in the same cycle");

    // finishing always delivers a flagged result
    a_finish_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_emit.finish |=> (o_res_valid && o_res.last))
        else $error("finish without a last result");
`endif

endmodule

### sv/graph_traversal_engine_top.sv
// top level: adjacency store, walk scratch memory and traversal sequencer
`timescale 1ns / 1ps

// Graph traversal engine. Requests are taken when start is high and busy is
// low. Clear returns straight to idle (row valid bits drop at once, no
// clearing pass); add edge steps through S_ADD_A and S_ADD_B (read-modify-
// write of both rows in the adjacency memory). A walk from node 0 keeps busy
// high through a scan for each node reached after node 0, a scan that finds
// nothing and then the row fetch behind the registered memory read for each
// node dequeued in BFS or popped in DFS, a final empty scan when the walk
// runs out of nodes, and a closing state. A DFS push needs no extra step since
// the child row is fetched in the cycle that reaches it. The adjacency and
// scratch memories both have a registered read. Results are strobed on
// o_res_valid one per cycle and cannot be held off by the receiver; the final
// one carries last. Node count writes are taken at any time but belong in
// idle periods.
module graph_traversal_engine_top #(
    parameter int MAX_NODES = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  gte_pkg::t_req              i_req,
    output logic                       o_res_valid,
    output gte_pkg::t_res              o_res,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [gte_pkg::CFG_W-1:0]  i_cfg_data
);
    import gte_pkg::*;

    localparam int NW = $clog2(MAX_NODES);
    localparam int PW = $clog2(MAX_NODES + 1);

    // state and registers
    t_state                 r_state, n_state;
    t_req                   r_req;
    logic [CFG_W-1:0]       r_node_count;
    logic [MAX_NODES-1:0]   r_visited, n_visited;
    logic [TALLY_W-1:0]     r_tally, n_tally;
    logic [PW-1:0]          r_head, n_head;
    logic [PW-1:0]          r_tail, n_tail;
    logic [PW-1:0]          r_sp, n_sp;

    // memories
    logic [MAX_NODES-1:0]   r_adj_mem [MAX_NODES];
    logic [MAX_NODES-1:0]   r_adj_q;
    logic                   r_adj_vq;
    logic [MAX_NODES-1:0]   r_row_vld;
    logic [NW-1:0]          r_scr_mem [MAX_NODES];
    logic [NW-1:0]          r_scr_q;

    // memory controls
    logic                   adj_rd_en;
    logic [NW-1:0]          adj_rd_addr;
    logic                   adj_wr_en;
    logic [NW-1:0]          adj_wr_addr;
    logic [MAX_NODES-1:0]   adj_wr_row;
    logic                   tbl_clear;
    logic                   scr_rd_en;
    logic [NW-1:0]          scr_rd_addr;
    logic                   scr_wr_en;
    logic [NW-1:0]          scr_wr_addr;
    logic [NW-1:0]          scr_wr_data;

    // datapath
    logic                   take;
    logic                   edge_ok;
    logic [PW-1:0]          count_eff;
    logic [MAX_NODES-1:0]   count_mask;
    logic [MAX_NODES-1:0]   row;
    logic [MAX_NODES-1:0]   cand;
    logic [MAX_NODES-1:0]   low;
    logic [NW-1:0]          idx;
    logic [TALLY_W-1:0]     tally_n;
    logic                   done;
    logic [PW-1:0]          sp_m2;
    logic [MAX_NODES-1:0]   bit_a;
    logic [MAX_NODES-1:0]   bit_b;
    t_emit                  emit;

    assign take        = start && !busy;
    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign edge_ok     = (int'(i_req.node_a) < MAX_NODES) && (int'(i_req.node_b) < MAX_NODES);

    // node count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= NODE_COUNT_RESET;
        end else if (i_cfg_valid) begin
            r_node_count <= i_cfg_data;
        end
    end

    // clamp node count to one .. MAX_NODES
    always_comb begin
        if (r_node_count == '0) begin
            count_eff = PW'(1);
        end else if (int'(r_node_count) > MAX_NODES) begin
            count_eff = PW'(MAX_NODES);
        end else begin
            count_eff = PW'(r_node_count);
        end
    end

    // nodes in use
    always_comb begin
        for (int j = 0; j < MAX_NODES; j++) begin
            count_mask[j] = (j < int'(count_eff));
        end
    end

    // unvisited neighbors of the fetched row, lowest first
    assign row  = r_adj_vq ? r_adj_q : '0;
    assign cand = row & ~r_visited & count_mask;
    assign low  = cand & (~cand + MAX_NODES'(1));

    always_comb begin
        idx = '0;
        for (int j = 0; j < MAX_NODES; j++) begin
            if (low[j]) begin
                idx = idx | NW'(j);
            end
        end
    end

    // walk stops on full visit or on the result limit
    assign tally_n = r_tally + TALLY_W'(1);
    assign done    = (int'(tally_n) >= int'(count_eff)) ||
                     (tally_n == TALLY_W'(MAX_RESULTS));
    assign sp_m2   = r_sp - PW'(2);
    assign bit_a   = MAX_NODES'(1) << r_req.node_a;
    assign bit_b   = MAX_NODES'(1) << r_req.node_b;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // walk counters and visited map
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_visited <= '0;
            r_tally   <= '0;
            r_head    <= '0;
            r_tail    <= '0;
            r_sp      <= '0;
        end else begin
            r_visited <= n_visited;
            r_tally   <= n_tally;
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_sp      <= n_sp;
        end
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_req <= i_req;
        end
    end

    // next state and memory controls
    always_comb begin
        n_state     = r_state;
        n_visited   = r_visited;
        n_tally     = r_tally;
        n_head      = r_head;
        n_tail      = r_tail;
        n_sp        = r_sp;
        adj_rd_en   = 1'b0;
        adj_rd_addr = idx;
        adj_wr_en   = 1'b0;
        adj_wr_addr = NW'(r_req.node_a);
        adj_wr_row  = row | bit_b;
        tbl_clear   = 1'b0;
        scr_rd_en   = 1'b0;
        scr_rd_addr = r_head[NW-1:0];
        scr_wr_en   = 1'b0;
        scr_wr_addr = r_tail[NW-1:0];
        scr_wr_data = idx;
        emit        = '0;
        emit.node   = NODE_W'(idx);

        unique case (r_state)
            S_IDLE: begin
                if (take) begin
                    unique case (i_req.mode)
                        MODE_CLEAR: begin
                            tbl_clear = 1'b1;
                        end
                        MODE_ADD: begin
                            if (edge_ok) begin
                                adj_rd_en   = 1'b1;
                                adj_rd_addr = NW'(i_req.node_a);
                                n_state     = S_ADD_A;
                            end
                        end
                        MODE_BFS, MODE_DFS: begin
                            // node 0 is reached at once and sits at the bottom frame
                            n_visited   = MAX_NODES'(1);
                            n_tally     = TALLY_W'(1);
                            n_head      = PW'(1);
                            n_tail      = PW'(1);
                            n_sp        = PW'(1);
                            emit.reach  = 1'b1;
                            emit.first  = 1'b1;
                            emit.node   = '0;
                            scr_wr_en   = 1'b1;
                            scr_wr_addr = '0;
                            scr_wr_data = '0;
                            if (count_eff == PW'(1)) begin
                                n_state = S_FIN;
                            end else begin
                                adj_rd_en   = 1'b1;
                                adj_rd_addr = '0;
                                n_state     = (i_req.mode == MODE_BFS) ? S_BSCAN : S_DSCAN;
                            end
                        end
                    endcase
                end
            end
            S_ADD_A: begin
                adj_wr_en   = 1'b1;
                adj_wr_addr = NW'(r_req.node_a);
                adj_wr_row  = row | bit_b;
                adj_rd_en   = 1'b1;
                adj_rd_addr = NW'(r_req.node_b);
                n_state     = S_ADD_B;
            end
            S_ADD_B: begin
                adj_wr_en   = 1'b1;
                adj_wr_addr = NW'(r_req.node_b);
                adj_wr_row  = row | bit_a;
                n_state     = S_IDLE;
            end
            S_BSCAN: begin
                if (cand != '0) begin
                    // reach and enqueue the next neighbor
                    n_visited   = r_visited | low;
                    n_tally     = tally_n;
                    emit.reach  = 1'b1;
                    scr_wr_en   = 1'b1;
                    scr_wr_addr = r_tail[NW-1:0];
                    n_tail      = r_tail + PW'(1);
                    if (done) begin
                        n_state = S_FIN;
                    end
                end else if (r_head == r_tail) begin
                    n_state = S_FIN;
                end else begin
                    // dequeue the next node
                    scr_rd_en   = 1'b1;
                    scr_rd_addr = r_head[NW-1:0];
                    n_head      = r_head + PW'(1);
                    n_state     = S_BNODE;
                end
            end
            S_BNODE: begin
                adj_rd_en   = 1'b1;
                adj_rd_addr = r_scr_q;
                n_state     = S_BSCAN;
            end
            S_DSCAN: begin
                if (cand != '0) begin
                    // reach the child and descend into it
                    n_visited  = r_visited | low;
                    n_tally    = tally_n;
                    emit.reach = 1'b1;
                    if (done) begin
                        n_state = S_FIN;
                    end else begin
                        scr_wr_en   = 1'b1;
                        scr_wr_addr = r_sp[NW-1:0];
                        n_sp        = r_sp + PW'(1);
                        adj_rd_en   = 1'b1;
                        adj_rd_addr = idx;
                    end
                end else if (r_sp == PW'(1)) begin
                    n_sp    = '0;
                    n_state = S_FIN;
                end else begin
                    // pop and fetch the parent frame
                    n_sp        = r_sp - PW'(1);
                    scr_rd_en   = 1'b1;
                    scr_rd_addr = sp_m2[NW-1:0];
                    n_state     = S_DPOP;
                end
            end
            S_DPOP: begin
                adj_rd_en   = 1'b1;
                adj_rd_addr = r_scr_q;
                n_state     = S_DSCAN;
            end
            S_FIN: begin
                emit.finish = 1'b1;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // adjacency memory
    always_ff @(posedge i_clk) begin
        if (adj_wr_en) begin
            r_adj_mem[adj_wr_addr] <= adj_wr_row;
        end
        if (adj_rd_en) begin
            r_adj_q <= r_adj_mem[adj_rd_addr];
        end
    end

    // row valid bits: a row never written reads as no edges
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
            r_adj_vq  <= 1'b0;
        end else begin
            if (tbl_clear) begin
                r_row_vld <= '0;
            end else if (adj_wr_en) begin
                r_row_vld[adj_wr_addr] <= 1'b1;
            end
            if (adj_rd_en) begin
                r_adj_vq <= r_row_vld[adj_rd_addr];
            end
        end
    end

    // queue and stack scratch memory
    always_ff @(posedge i_clk) begin
        if (scr_wr_en) begin
            r_scr_mem[scr_wr_addr] <= scr_wr_data;
        end
        if (scr_rd_en) begin
            r_scr_q <= r_scr_mem[scr_rd_addr];
        end
    end

    // result stage
    gte_result_out u_result_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_emit      (emit),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );

`ifndef NO_ASSERTIONS
    // every reached node is counted exactly once
    a_tally_matches_visited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BSCAN || r_state == S_DSCAN) |->
            ($countones(r_visited) == int'(r_tally)))
        else $error("visited map and tally disagree");

    // the queue never runs past its tail
    a_bfs_head_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BSCAN) |-> (r_head <= r_tail))
        else $error("queue head beyond tail");

    // a depth-first scan always has a frame
    a_dfs_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DSCAN || r_state == S_DPOP) |-> (r_sp != '0))
        else $error("depth-first scan with empty stack");

    // results only follow walk activity
    a_res_from_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> ($past(r_state) == S_BSCAN || $past(r_state) == S_DSCAN ||
                         $past(r_state) == S_FIN))
        else $error("result outside a walk");
`endif

endmodule
